// ----- hw/rtl/glyph_tile_color_generator_defines.svh -----
`ifndef GLYPH_TILE_COLOR_GENERATOR_DEFINES_SVH
`define GLYPH_TILE_COLOR_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk and ignored while rst_n is low.
`define GTCG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and ignored while rst_n is low.
`define GTCG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/gtcg_pkg.sv -----
`timescale 1ns / 1ps

package gtcg_pkg;

  localparam int GlyphCount    = 14;
  localparam int GlyphSize     = 5;
  localparam int VarCount      = 100;
  localparam int ShadeCount    = 192;
  localparam int CfgAddrW      = 5;
  localparam int CfgDataW      = 32;

  localparam logic [7:0] ShadeAlpha     = 8'b1011_1111;
  localparam logic [7:0] ContrastBg     = 8'b1100_0000;
  localparam logic [7:0] ContrastNumLow = 8'b1111_1111;
  localparam logic [7:0] ContrastNumHi  = 8'b1100_0000;
  localparam logic [7:0] ContrastOrn    = 8'b1100_0001;
  localparam logic [4:0] ShadeFromSlot  = 5'd8;
  localparam logic [9:0] GlyphStep      = 10'd17;
  localparam logic [9:0] SlotStep       = 10'd19;

  localparam logic [7:0] BgReset        = 8'd192;
  localparam logic [7:0] NumReset       = 8'd202;
  localparam logic [7:0] OrnReset       = 8'd226;

  typedef enum logic [1:0] {
    CODE_BG  = 2'd0,
    CODE_NUM = 2'd1,
    CODE_ORN = 2'd2
  } tile_code_t;

  typedef enum logic [2:0] {
    REG_BG_COLOR  = 3'd0,
    REG_NUM_COLOR = 3'd1,
    REG_ORN_COLOR = 3'd2,
    REG_NUM_VAR   = 3'd3,
    REG_ORN_VAR   = 3'd4,
    REG_CONTRAST  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] bg_color;
    logic [7:0] number_color;
    logic [7:0] ornament_color;
    logic       number_variation_on;
    logic       ornament_variation_on;
    logic       contrast_mode;
  } gtcg_cfg_t;

  // One glyph row; column 0 is the leftmost two bits of each literal.
  typedef logic [0:GlyphSize-1][1:0] font_row_t;

  localparam font_row_t FONT_ROM [GlyphCount][GlyphSize] = '{
    '{10'b01_01_01_01_01, 10'b01_00_00_00_01, 10'b01_00_10_00_01,
      10'b01_00_00_00_01, 10'b01_01_01_01_01},
    '{10'b10_10_00_01_01, 10'b00_00_00_00_01, 10'b10_10_10_00_01,
      10'b00_00_00_00_01, 10'b10_10_10_00_01},
    '{10'b01_01_01_01_01, 10'b00_00_00_00_01, 10'b01_01_01_01_01,
      10'b01_00_00_00_00, 10'b01_01_01_01_01},
    '{10'b01_01_01_01_01, 10'b00_00_00_00_01, 10'b00_01_01_01_01,
      10'b00_00_00_00_01, 10'b01_01_01_01_01},
    '{10'b01_00_10_00_01, 10'b01_00_00_00_01, 10'b01_01_01_01_01,
      10'b00_00_00_00_01, 10'b10_10_10_00_01},
    '{10'b01_01_01_01_01, 10'b01_00_00_00_00, 10'b01_01_01_01_01,
      10'b00_00_00_00_01, 10'b01_01_01_01_01},
    '{10'b01_01_01_01_01, 10'b01_00_00_00_00, 10'b01_01_01_01_01,
      10'b01_00_00_00_01, 10'b01_01_01_01_01},
    '{10'b01_01_01_01_01, 10'b00_00_00_00_01, 10'b10_00_10_00_01,
      10'b10_00_10_00_01, 10'b10_00_10_00_01},
    '{10'b01_01_01_01_01, 10'b01_00_00_00_01, 10'b01_01_01_01_01,
      10'b01_00_00_00_01, 10'b01_01_01_01_01},
    '{10'b01_01_01_01_01, 10'b01_00_00_00_01, 10'b01_01_01_01_01,
      10'b00_00_00_00_01, 10'b01_01_01_01_01},
    '{10'b10_10_10_10_10, 10'b00_00_00_00_00, 10'b10_10_10_10_10,
      10'b00_00_00_00_00, 10'b10_10_10_10_10},
    '{10'b10_00_10_00_10, 10'b10_00_10_00_10, 10'b10_00_10_00_10,
      10'b10_00_10_00_10, 10'b10_00_10_00_10},
    '{10'b01_01_01_01_01, 10'b00_00_00_00_00, 10'b01_01_01_01_01,
      10'b00_00_00_00_00, 10'b01_01_01_01_01},
    '{10'b01_00_01_00_01, 10'b01_00_01_00_01, 10'b01_00_01_00_01,
      10'b01_00_01_00_01, 10'b01_00_01_00_01}
  };

  localparam logic [7:0] VAR_ROM [VarCount] = '{
    8'h00, 8'h10, 8'h04, 8'h10, 8'h00, 8'h11, 8'h10, 8'h00, 8'h05, 8'h10,
    8'h01, 8'h00, 8'h00, 8'h14, 8'h11, 8'h00, 8'h11, 8'h05, 8'h11, 8'h14,
    8'h00, 8'h11, 8'h05, 8'h00, 8'h01, 8'h04, 8'h14, 8'h14, 8'h01, 8'h14,
    8'h11, 8'h01, 8'h15, 8'h15, 8'h10, 8'h00, 8'h14, 8'h11, 8'h14, 8'h04,
    8'h14, 8'h15, 8'h11, 8'h11, 8'h15, 8'h10, 8'h10, 8'h00, 8'h10, 8'h01,
    8'h01, 8'h00, 8'h14, 8'h00, 8'h14, 8'h14, 8'h01, 8'h05, 8'h10, 8'h10,
    8'h01, 8'h10, 8'h00, 8'h01, 8'h00, 8'h14, 8'h04, 8'h01, 8'h10, 8'h10,
    8'h01, 8'h01, 8'h05, 8'h15, 8'h00, 8'h10, 8'h01, 8'h01, 8'h10, 8'h00,
    8'h04, 8'h10, 8'h14, 8'h10, 8'h14, 8'h04, 8'h15, 8'h15, 8'h10, 8'h15,
    8'h05, 8'h01, 8'h14, 8'h14, 8'h00, 8'h00, 8'h01, 8'h11, 8'h05, 8'h14
  };

  localparam logic [7:0] SHADE_ROM [ShadeCount] = '{
    8'd192, 8'd192, 8'd192, 8'd192, 8'd192, 8'd192, 8'd192, 8'd192,
    8'd192, 8'd192, 8'd192, 8'd192, 8'd192, 8'd192, 8'd192, 8'd192,
    8'd192, 8'd192, 8'd192, 8'd192, 8'd192, 8'd192, 8'd192, 8'd192,
    8'd192, 8'd192, 8'd192, 8'd192, 8'd192, 8'd192, 8'd192, 8'd192,
    8'd192, 8'd192, 8'd192, 8'd192, 8'd192, 8'd192, 8'd192, 8'd192,
    8'd192, 8'd192, 8'd192, 8'd192, 8'd192, 8'd192, 8'd192, 8'd192,
    8'd192, 8'd192, 8'd192, 8'd192, 8'd192, 8'd192, 8'd192, 8'd192,
    8'd192, 8'd192, 8'd192, 8'd192, 8'd192, 8'd192, 8'd192, 8'd192,
    8'd192, 8'd192, 8'd192, 8'd193, 8'd192, 8'd192, 8'd192, 8'd193,
    8'd192, 8'd192, 8'd192, 8'd193, 8'd196, 8'd196, 8'd196, 8'd197,
    8'd192, 8'd192, 8'd192, 8'd193, 8'd192, 8'd192, 8'd192, 8'd193,
    8'd192, 8'd192, 8'd192, 8'd193, 8'd196, 8'd196, 8'd196, 8'd197,
    8'd192, 8'd192, 8'd192, 8'd193, 8'd192, 8'd192, 8'd192, 8'd193,
    8'd192, 8'd192, 8'd192, 8'd193, 8'd196, 8'd196, 8'd196, 8'd197,
    8'd208, 8'd208, 8'd208, 8'd209, 8'd208, 8'd208, 8'd208, 8'd209,
    8'd208, 8'd208, 8'd208, 8'd209, 8'd212, 8'd212, 8'd212, 8'd213,
    8'd192, 8'd192, 8'd193, 8'd194, 8'd192, 8'd192, 8'd193, 8'd194,
    8'd196, 8'd196, 8'd197, 8'd198, 8'd200, 8'd200, 8'd201, 8'd202,
    8'd192, 8'd192, 8'd193, 8'd194, 8'd192, 8'd192, 8'd193, 8'd194,
    8'd196, 8'd196, 8'd197, 8'd198, 8'd200, 8'd200, 8'd201, 8'd202,
    8'd208, 8'd208, 8'd209, 8'd210, 8'd208, 8'd208, 8'd209, 8'd210,
    8'd212, 8'd212, 8'd213, 8'd214, 8'd216, 8'd216, 8'd217, 8'd218,
    8'd224, 8'd224, 8'd225, 8'd226, 8'd224, 8'd224, 8'd225, 8'd226,
    8'd228, 8'd228, 8'd229, 8'd230, 8'd232, 8'd232, 8'd233, 8'd234
  };

  // Tiles outside the 5x5 grid or the glyph set read as background.
  function automatic tile_code_t font_code(logic [2:0] col, logic [2:0] row,
                                           logic [3:0] glyph);
    tile_code_t code;
    if (col > 3'd4 || row > 3'd4 || glyph > 4'd13) begin
      code = CODE_BG;
    end else begin
      code = tile_code_t'(FONT_ROM[glyph][row][col]);
    end
    return code;
  endfunction

endpackage

// ----- hw/rtl/gtcg_cfg_regs.sv -----
`timescale 1ns / 1ps

module gtcg_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [gtcg_pkg::CfgAddrW-1:0]       paddr,
  input  logic [gtcg_pkg::CfgDataW-1:0]       pwdata,
  output logic [gtcg_pkg::CfgDataW-1:0]       prdata,
  output logic                                pready,
  output gtcg_pkg::gtcg_cfg_t                 cfg
);
  import gtcg_pkg::*;

  gtcg_cfg_t cfg_r;
  gtcg_cfg_t cfg_nxt;
  cfg_reg_t  reg_sel;
  logic      wr_en;

  assign reg_sel = cfg_reg_t'(paddr[CfgAddrW-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_sel)
        REG_BG_COLOR:  cfg_nxt.bg_color              = pwdata[7:0];
        REG_NUM_COLOR: cfg_nxt.number_color          = pwdata[7:0];
        REG_ORN_COLOR: cfg_nxt.ornament_color        = pwdata[7:0];
        REG_NUM_VAR:   cfg_nxt.number_variation_on   = pwdata[0];
        REG_ORN_VAR:   cfg_nxt.ornament_variation_on = pwdata[0];
        REG_CONTRAST:  cfg_nxt.contrast_mode         = pwdata[0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_BG_COLOR:  prdata = {24'd0, cfg_r.bg_color};
      REG_NUM_COLOR: prdata = {24'd0, cfg_r.number_color};
      REG_ORN_COLOR: prdata = {24'd0, cfg_r.ornament_color};
      REG_NUM_VAR:   prdata = {31'd0, cfg_r.number_variation_on};
      REG_ORN_VAR:   prdata = {31'd0, cfg_r.ornament_variation_on};
      REG_CONTRAST:  prdata = {31'd0, cfg_r.contrast_mode};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bg_color              <= BgReset;
      cfg_r.number_color          <= NumReset;
      cfg_r.ornament_color        <= OrnReset;
      cfg_r.number_variation_on   <= 1'b1;
      cfg_r.ornament_variation_on <= 1'b1;
      cfg_r.contrast_mode         <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- hw/rtl/glyph_tile_color_generator.sv -----
`timescale 1ns / 1ps
// An accepted item passes through the stage-one registers and then the out_color register.
// Throughput: one item per cycle; busy is always low, as the two register stages never stall.
// The first stage does the font lookup and the variation index modulo 100.
// The second stage does the variation add, the shadow lookup and the background compare.
// Reset (rst_n low, synchronous) drops all pending items and restores register defaults.
`include "glyph_tile_color_generator_defines.svh"

module glyph_tile_color_generator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [2:0]                      in_tile_column,
  input  logic [2:0]                      in_tile_row,
  input  logic [3:0]                      in_glyph,
  input  logic [4:0]                      in_slot_position,
  output logic                            out_valid,
  output logic [7:0]                      out_color,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gtcg_pkg::CfgAddrW-1:0]   paddr,
  input  logic [gtcg_pkg::CfgDataW-1:0]   pwdata,
  output logic [gtcg_pkg::CfgDataW-1:0]   prdata,
  output logic                            pready
);
  import gtcg_pkg::*;

  gtcg_cfg_t  cfg;

  logic       accept;
  tile_code_t code_nxt;
  logic [9:0] idx_sum;
  logic [15:0] idx_prod;
  logic [3:0] idx_quot;
  logic [9:0] idx_rem;
  logic [9:0] idx_fix;
  logic [6:0] idx_nxt;

  logic       s1_valid_r;
  tile_code_t s1_code_r;
  logic [6:0] s1_idx_r;
  logic       s1_shaded_r;

  logic [7:0] base_color;
  logic       add_var;
  logic [7:0] var_byte;
  logic [7:0] sum_color;
  logic [7:0] shade_color;
  logic [7:0] out_color_nxt;

  logic       out_valid_r;
  logic [7:0] out_color_r;

  gtcg_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Variation index: floor(x / 100) is (x * 41) >> 12 for every x below 1024.
  always_comb begin
    code_nxt = font_code(in_tile_column, in_tile_row, in_glyph);
    idx_sum  = 10'(in_tile_row) * 10'd5 + 10'(in_tile_column)
             + 10'(in_glyph) * GlyphStep + 10'(in_slot_position) * SlotStep;
    idx_prod = 16'(idx_sum) * 16'd41;
    idx_quot = idx_prod[15:12];
    idx_rem  = idx_sum - 10'(idx_quot) * 10'(VarCount);
    idx_fix  = (idx_rem >= 10'(VarCount)) ? idx_rem - 10'(VarCount) : idx_rem;
    idx_nxt  = idx_fix[6:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_code_r   <= code_nxt;
      s1_idx_r    <= idx_nxt;
      s1_shaded_r <= in_slot_position >= ShadeFromSlot;
    end
  end

  always_comb begin
    base_color = cfg.bg_color;
    add_var    = 1'b0;
    case (s1_code_r)
      CODE_NUM: begin
        if (cfg.contrast_mode) begin
          base_color = s1_shaded_r ? ContrastNumHi : ContrastNumLow;
        end else begin
          base_color = cfg.number_color;
          add_var    = cfg.number_variation_on;
        end
      end
      CODE_ORN: begin
        if (cfg.contrast_mode) begin
          base_color = ContrastOrn;
        end else begin
          base_color = cfg.ornament_color;
          add_var    = cfg.ornament_variation_on;
        end
      end
      default: begin
        base_color = cfg.contrast_mode ? ContrastBg : cfg.bg_color;
      end
    endcase
    var_byte    = add_var ? VAR_ROM[s1_idx_r] : 8'd0;
    sum_color   = base_color + var_byte;
    shade_color = SHADE_ROM[sum_color & ShadeAlpha];
    if (s1_code_r != CODE_BG && s1_shaded_r && shade_color != cfg.bg_color) begin
      out_color_nxt = shade_color;
    end else begin
      out_color_nxt = sum_color;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      out_color_r <= out_color_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_color = out_color_r;

  `GTCG_ASSERT_NEXT(a_accept_to_stage, accept, s1_valid_r, "item did not enter stage one")
  `GTCG_ASSERT_NEXT(a_stage_to_out, s1_valid_r,
                    out_valid_r && out_color_r == $past(out_color_nxt), "stage one item lost")
  `GTCG_ASSERT_NOW(a_idx_range, s1_valid_r, s1_idx_r < 7'(VarCount), "index out of range")
  `GTCG_ASSERT_NOW(a_bg_plain, s1_valid_r && s1_code_r == CODE_BG && !cfg.contrast_mode,
                   out_color_nxt == cfg.bg_color, "background tile not given background color")

endmodule

// ----- test/tb_glyph_tile_color_generator.sv -----
`timescale 1ns / 1ps

module tb_glyph_tile_color_generator;
  import gtcg_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PIPE_DRAIN = 4;
  localparam int PHASE_COUNT = 8;
  localparam int PHASE_TILES = 110;
  localparam int DIRECTED_COUNT = 22;
  localparam logic PREDICT = 1'b0;
  localparam logic TYPED = 1'b1;

  localparam logic [7:0] SHADE_MASK = 8'hBF;
  localparam logic [7:0] BLACK = 8'hC0;
  localparam logic [7:0] WHITE = 8'hFF;
  localparam logic [7:0] ORNAMENT_CONTRAST = 8'hC1;

  // One hex digit per tile, row 0 first: 0 background, 1 number, 2 ornament.
  localparam logic [0:13][99:0] GLYPH_ART = {
    100'h11111_10001_10201_10001_11111,
    100'h22011_00001_22201_00001_22201,
    100'h11111_00001_11111_10000_11111,
    100'h11111_00001_01111_00001_11111,
    100'h10201_10001_11111_00001_22201,
    100'h11111_10000_11111_00001_11111,
    100'h11111_10000_11111_10001_11111,
    100'h11111_00001_20201_20201_20201,
    100'h11111_10001_11111_10001_11111,
    100'h11111_10001_11111_00001_11111,
    100'h22222_00000_22222_00000_22222,
    100'h20202_20202_20202_20202_20202,
    100'h11111_00000_11111_00000_11111,
    100'h10101_10101_10101_10101_10101
  };

  localparam logic [0:99][7:0] VARIATION = {
    8'h00, 8'h10, 8'h04, 8'h10, 8'h00, 8'h11, 8'h10, 8'h00, 8'h05, 8'h10,
    8'h01, 8'h00, 8'h00, 8'h14, 8'h11, 8'h00, 8'h11, 8'h05, 8'h11, 8'h14,
    8'h00, 8'h11, 8'h05, 8'h00, 8'h01, 8'h04, 8'h14, 8'h14, 8'h01, 8'h14,
    8'h11, 8'h01, 8'h15, 8'h15, 8'h10, 8'h00, 8'h14, 8'h11, 8'h14, 8'h04,
    8'h14, 8'h15, 8'h11, 8'h11, 8'h15, 8'h10, 8'h10, 8'h00, 8'h10, 8'h01,
    8'h01, 8'h00, 8'h14, 8'h00, 8'h14, 8'h14, 8'h01, 8'h05, 8'h10, 8'h10,
    8'h01, 8'h10, 8'h00, 8'h01, 8'h00, 8'h14, 8'h04, 8'h01, 8'h10, 8'h10,
    8'h01, 8'h01, 8'h05, 8'h15, 8'h00, 8'h10, 8'h01, 8'h01, 8'h10, 8'h00,
    8'h04, 8'h10, 8'h14, 8'h10, 8'h14, 8'h04, 8'h15, 8'h15, 8'h10, 8'h15,
    8'h05, 8'h01, 8'h14, 8'h14, 8'h00, 8'h00, 8'h01, 8'h11, 8'h05, 8'h14
  };

  typedef struct packed {
    logic       contrast;
    logic [2:0] col;
    logic [2:0] row;
    logic [3:0] glyph;
    logic [4:0] slot;
    logic       known;
    logic [7:0] color;
  } tile_case_t;

  typedef struct {
    logic [2:0] col;
    logic [2:0] row;
    logic [3:0] glyph;
    logic [4:0] slot;
    logic [7:0] color;
  } tile_expect_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] in_tile_column = '0;
  logic [2:0] in_tile_row = '0;
  logic [3:0] in_glyph = '0;
  logic [4:0] in_slot_position = '0;
  logic out_valid;
  logic [7:0] out_color;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [CfgDataW-1:0] pwdata = '0;
  logic [CfgDataW-1:0] prdata;
  logic pready;

  logic typed_known = 1'b0;
  logic [7:0] typed_color = '0;

  logic [7:0] bg_setting;
  logic [7:0] num_setting;
  logic [7:0] orn_setting;
  logic num_var_on;
  logic orn_var_on;
  logic contrast_on;

  tile_expect_t color_queue[$];
  tile_expect_t accepted_tile;
  tile_expect_t oldest_tile;
  tile_case_t directed_cases [DIRECTED_COUNT];
  int mismatch_count = 0;
  int cycle_count = 0;
  int sender_idle_pct = 0;

  glyph_tile_color_generator i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_tile_column   (in_tile_column),
    .in_tile_row      (in_tile_row),
    .in_glyph         (in_glyph),
    .in_slot_position (in_slot_position),
    .out_valid        (out_valid),
    .out_color        (out_color),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #2 clk = ~clk;

  function automatic tile_code_t glyph_tile(logic [2:0] col, logic [2:0] row,
                                            logic [3:0] glyph);
    int tile;
    logic [3:0] digit;
    if (col > 3'd4 || row > 3'd4 || glyph > 4'd13) begin
      return CODE_BG;
    end
    tile = int'(row) * 5 + int'(col);
    digit = GLYPH_ART[glyph][(24 - tile) * 4 +: 4];
    return tile_code_t'(digit[1:0]);
  endfunction

  function automatic logic [1:0] dim_level(logic [1:0] level);
    return (level == 2'd0) ? 2'd0 : level - 2'd1;
  endfunction

  function automatic logic [7:0] shadow_color(logic [7:0] color);
    logic [7:0] idx;
    idx = color & SHADE_MASK;
    if (!idx[7]) begin
      return BLACK;
    end
    return {2'b11, dim_level(idx[5:4]), dim_level(idx[3:2]), dim_level(idx[1:0])};
  endfunction

  function automatic logic [7:0] predict_color(logic [2:0] col, logic [2:0] row,
                                               logic [3:0] glyph, logic [4:0] slot);
    tile_code_t code;
    logic shaded;
    logic add_var;
    logic [7:0] color;
    logic [7:0] shade;
    int idx;
    code = glyph_tile(col, row, glyph);
    shaded = slot >= 5'd8;
    add_var = 1'b0;
    if (code == CODE_BG) begin
      return contrast_on ? BLACK : bg_setting;
    end
    if (code == CODE_NUM) begin
      if (contrast_on) begin
        color = shaded ? BLACK : WHITE;
      end else begin
        color = num_setting;
        add_var = num_var_on;
      end
    end else begin
      if (contrast_on) begin
        color = ORNAMENT_CONTRAST;
      end else begin
        color = orn_setting;
        add_var = orn_var_on;
      end
    end
    if (add_var) begin
      idx = (int'(row) * 5 + int'(col) + int'(glyph) * 17 + int'(slot) * 19) % 100;
      color = color + VARIATION[idx];
    end
    if (shaded) begin
      shade = shadow_color(color);
      if (shade != bg_setting) begin
        color = shade;
      end
    end
    return color;
  endfunction

  task automatic note_error(string what);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      bg_setting <= BgReset;
      num_setting <= NumReset;
      orn_setting <= OrnReset;
      num_var_on <= 1'b1;
      orn_var_on <= 1'b1;
      contrast_on <= 1'b0;
    end else begin
      if (out_valid) begin
        if (color_queue.size() == 0) begin
          note_error($sformatf("color %0d with no item outstanding", out_color));
        end else begin
          oldest_tile = color_queue.pop_front();
          if (out_color !== oldest_tile.color) begin
            note_error($sformatf("col %0d row %0d glyph %0d slot %0d: expected %0d, got %0d",
                                 oldest_tile.col, oldest_tile.row, oldest_tile.glyph,
                                 oldest_tile.slot, oldest_tile.color, out_color));
          end
        end
      end
      if (start && !busy) begin
        accepted_tile.col = in_tile_column;
        accepted_tile.row = in_tile_row;
        accepted_tile.glyph = in_glyph;
        accepted_tile.slot = in_slot_position;
        accepted_tile.color = typed_known ? typed_color :
            predict_color(in_tile_column, in_tile_row, in_glyph, in_slot_position);
        color_queue.push_back(accepted_tile);
      end
      if (psel && penable && pwrite && pready) begin
        case (cfg_reg_t'(paddr[CfgAddrW-1:2]))
          REG_BG_COLOR: begin
            bg_setting <= pwdata[7:0];
          end
          REG_NUM_COLOR: begin
            num_setting <= pwdata[7:0];
          end
          REG_ORN_COLOR: begin
            orn_setting <= pwdata[7:0];
          end
          REG_NUM_VAR: begin
            num_var_on <= pwdata[0];
          end
          REG_ORN_VAR: begin
            orn_var_on <= pwdata[0];
          end
          REG_CONTRAST: begin
            contrast_on <= pwdata[0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  task automatic wait_idle();
    start <= 1'b0;
    while (color_queue.size() != 0) begin
      @(posedge clk);
    end
    repeat (PIPE_DRAIN) @(posedge clk);
  endtask

  task automatic program_setting(cfg_reg_t which, logic [7:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {which, 2'b00};
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== 32'(value)) begin
      note_error($sformatf("register %s read back %0d, expected %0d",
                           which.name(), prdata, value));
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(logic [7:0] bg, logic [7:0] num, logic [7:0] orn,
                                logic nvar, logic ovar, logic contrast);
    wait_idle();
    program_setting(REG_BG_COLOR, bg);
    program_setting(REG_NUM_COLOR, num);
    program_setting(REG_ORN_COLOR, orn);
    program_setting(REG_NUM_VAR, 8'(nvar));
    program_setting(REG_ORN_VAR, 8'(ovar));
    program_setting(REG_CONTRAST, 8'(contrast));
  endtask

  task automatic send_tile(logic [2:0] col, logic [2:0] row, logic [3:0] glyph,
                           logic [4:0] slot, logic known, logic [7:0] color);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_tile_column <= col;
    in_tile_row <= row;
    in_glyph <= glyph;
    in_slot_position <= slot;
    typed_known <= known;
    typed_color <= color;
    do @(posedge clk); while (busy);
  endtask

  task automatic send_random_tile();
    logic [2:0] col;
    logic [2:0] row;
    logic [3:0] glyph;
    logic [4:0] slot;
    if ($urandom_range(99) < 85) begin
      col = 3'($urandom_range(4));
      row = 3'($urandom_range(4));
      glyph = 4'($urandom_range(13));
      slot = 5'($urandom_range(17));
    end else begin
      col = 3'($urandom_range(7));
      row = 3'($urandom_range(7));
      glyph = 4'($urandom_range(15));
      slot = 5'($urandom_range(31));
    end
    send_tile(col, row, glyph, slot, PREDICT, 8'h00);
  endtask

  initial begin
    logic [7:0] bg;
    logic [7:0] num;
    logic [7:0] orn;
    logic nvar;
    logic ovar;
    logic contrast;

    directed_cases = '{
      '{1'b0, 3'd0, 3'd0, 4'd0,  5'd0,  PREDICT, 8'h00},
      '{1'b0, 3'd1, 3'd1, 4'd0,  5'd0,  TYPED,   8'd192},
      '{1'b0, 3'd2, 3'd2, 4'd0,  5'd0,  PREDICT, 8'h00},
      '{1'b0, 3'd2, 3'd2, 4'd0,  5'd8,  PREDICT, 8'h00},
      '{1'b0, 3'd0, 3'd0, 4'd0,  5'd31, PREDICT, 8'h00},
      '{1'b0, 3'd7, 3'd0, 4'd0,  5'd0,  TYPED,   8'd192},
      '{1'b0, 3'd0, 3'd7, 4'd0,  5'd0,  TYPED,   8'd192},
      '{1'b0, 3'd4, 3'd4, 4'd15, 5'd31, TYPED,   8'd192},
      '{1'b0, 3'd4, 3'd4, 4'd13, 5'd17, PREDICT, 8'h00},
      '{1'b0, 3'd7, 3'd7, 4'd15, 5'd31, TYPED,   8'd192},
      '{1'b0, 3'd0, 3'd0, 4'd14, 5'd5,  TYPED,   8'd192},
      '{1'b0, 3'd4, 3'd4, 4'd12, 5'd16, PREDICT, 8'h00},
      '{1'b0, 3'd0, 3'd0, 4'd10, 5'd9,  PREDICT, 8'h00},
      '{1'b0, 3'd1, 3'd0, 4'd11, 5'd0,  TYPED,   8'd192},
      '{1'b0, 3'd1, 3'd1, 4'd9,  5'd3,  TYPED,   8'd192},
      '{1'b1, 3'd0, 3'd0, 4'd0,  5'd0,  TYPED,   8'hFF},
      '{1'b1, 3'd0, 3'd0, 4'd0,  5'd8,  TYPED,   8'hC0},
      '{1'b1, 3'd2, 3'd2, 4'd0,  5'd0,  TYPED,   8'hC1},
      '{1'b1, 3'd2, 3'd2, 4'd0,  5'd31, TYPED,   8'hC1},
      '{1'b1, 3'd1, 3'd1, 4'd0,  5'd20, TYPED,   8'hC0},
      '{1'b1, 3'd7, 3'd7, 4'd15, 5'd0,  TYPED,   8'hC0},
      '{1'b1, 3'd0, 3'd0, 4'd12, 5'd7,  TYPED,   8'hFF}
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      if (directed_cases[i].contrast != contrast_on) begin
        wait_idle();
        program_setting(REG_CONTRAST, 8'(directed_cases[i].contrast));
      end
      send_tile(directed_cases[i].col, directed_cases[i].row, directed_cases[i].glyph,
                directed_cases[i].slot, directed_cases[i].known, directed_cases[i].color);
    end

    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: begin
          bg = BgReset; num = NumReset; orn = OrnReset; nvar = 1'b1; ovar = 1'b1;
          contrast = 1'b0;
        end
        1: begin
          bg = 8'd0; num = 8'd255; orn = 8'd255; nvar = 1'b1; ovar = 1'b1;
          contrast = 1'b0;
        end
        2: begin
          bg = 8'd255; num = 8'd0; orn = 8'd0; nvar = 1'b0; ovar = 1'b0;
          contrast = 1'b0;
        end
        3: begin
          bg = 8'd200; num = 8'h55; orn = 8'hAA; nvar = 1'b1; ovar = 1'b0;
          contrast = 1'b1;
        end
        default: begin
          bg = ($urandom_range(1) == 0) ? 8'(192 + $urandom_range(42)) : 8'($urandom);
          num = 8'($urandom);
          orn = 8'($urandom);
          nvar = 1'($urandom);
          ovar = 1'($urandom);
          contrast = ($urandom_range(3) == 0);
        end
      endcase
      apply_settings(bg, num, orn, nvar, ovar, contrast);
      case (p % 4)
        1: sender_idle_pct = 80;
        3: sender_idle_pct = 19;
        default: sender_idle_pct = 0;
      endcase
      for (int i = 0; i < PHASE_TILES; i++) begin
        if (i == PHASE_TILES / 2) begin
          wait_idle();
        end
        send_random_tile();
      end
    end

    wait_idle();
    mismatch_count += color_queue.size();
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
